// File: design/vconv2_pkg.sv
// shared constants, register indexes and transaction types for the
// 2x2 valid-region convolution block; no dependencies
package vconv2_pkg;

  localparam int PIXEL_W       = 16;
  localparam int COEFF_W       = 16;
  localparam int DIM_W         = 11;
  localparam int IDX_W         = 10;
  localparam int PROD_W        = 32;
  localparam int RESULT_W      = 34;
  localparam int WIN           = 2;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [COEFF_W-1:0] COEFF_TL_RST = 16'sd1;
  localparam logic [COEFF_W-1:0] COEFF_TR_RST = 16'sd0;
  localparam logic [COEFF_W-1:0] COEFF_BL_RST = 16'sd1;
  localparam logic [COEFF_W-1:0] COEFF_BR_RST = 16'sd0;
  localparam logic [DIM_W-1:0]   WIDTH_RST    = 11'd3;
  localparam logic [DIM_W-1:0]   HEIGHT_RST   = 11'd3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEFF_TL  = 3'd0,
    REG_COEFF_TR  = 3'd1,
    REG_COEFF_BL  = 3'd2,
    REG_COEFF_BR  = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_HEIGHT    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] tl;
    logic signed [COEFF_W-1:0] tr;
    logic signed [COEFF_W-1:0] bl;
    logic signed [COEFF_W-1:0] br;
  } coeff_t;

  typedef struct packed {
    logic signed [PIXEL_W-1:0] above;
    logic signed [PIXEL_W-1:0] px;
    logic                      has_out;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic                      frame_end;
  } win_item_t;

endpackage

// File: design/vconv2_if.sv
// pixel input and result output channel interfaces
// depends on vconv2_pkg
interface vconv2_in_if import vconv2_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PIXEL_W-1:0] pixel;
  logic                      frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface vconv2_out_if import vconv2_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] result;
  logic [IDX_W-1:0]           out_row;
  logic [IDX_W-1:0]           out_col;
  logic                       frame_end;

  modport source (output valid, output result, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink   (input valid, input result, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

// File: design/vconv2_mac.sv
// multiply-accumulate pipeline: window registers, four products, adder tree
// and output register; depends on vconv2_pkg and vconv2_out_if
module vconv2_mac import vconv2_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  win_item_t    item,
  input  coeff_t       coeff,
  vconv2_out_if.source out_if
);

  logic signed [PIXEL_W-1:0]  ul_r, left_r;
  logic                       v2_r, v3_r, vo_r;
  logic signed [PROD_W-1:0]   p_tl_r, p_tr_r, p_bl_r, p_br_r;
  logic signed [PROD_W:0]     sa_r, sb_r;
  logic signed [RESULT_W-1:0] res_r;
  logic [IDX_W-1:0]           row2_r, col2_r, row3_r, col3_r, rowo_r, colo_r;
  logic                       fe2_r, fe3_r, feo_r;
  logic                       en2, en3, eno;

  assign eno      = !vo_r || out_if.ready;
  assign en3      = !v3_r || eno;
  assign en2      = !v2_r || en3;
  assign in_ready = en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      vo_r   <= 1'b0;
      ul_r   <= '0;
      left_r <= '0;
    end else begin
      if (en2) begin
        v2_r <= in_valid && item.has_out;
        if (in_valid) begin
          ul_r   <= item.above;
          left_r <= item.px;
        end
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (eno) begin
        vo_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && in_valid) begin
      p_tl_r <= PROD_W'(coeff.tl) * PROD_W'(ul_r);
      p_tr_r <= PROD_W'(coeff.tr) * PROD_W'(item.above);
      p_bl_r <= PROD_W'(coeff.bl) * PROD_W'(left_r);
      p_br_r <= PROD_W'(coeff.br) * PROD_W'(item.px);
      row2_r <= item.row;
      col2_r <= item.col;
      fe2_r  <= item.frame_end;
    end
    if (en3) begin
      sa_r   <= (PROD_W+1)'(p_tl_r) + (PROD_W+1)'(p_tr_r);
      sb_r   <= (PROD_W+1)'(p_bl_r) + (PROD_W+1)'(p_br_r);
      row3_r <= row2_r;
      col3_r <= col2_r;
      fe3_r  <= fe2_r;
    end
    if (eno) begin
      res_r  <= RESULT_W'(sa_r) + RESULT_W'(sb_r);
      rowo_r <= row3_r;
      colo_r <= col3_r;
      feo_r  <= fe3_r;
    end
  end

  assign out_if.valid     = vo_r;
  assign out_if.result    = res_r;
  assign out_if.out_row   = rowo_r;
  assign out_if.out_col   = colo_r;
  assign out_if.frame_end = feo_r;

endmodule

// File: design/valid_convolution_2x2.sv
// 2x2 valid-region convolution over a raster pixel stream, top level
// throughput: one pixel per cycle unless out_if.ready stalls, set by the single
// read-first port of the line store; stages: line store, products, sums, output
// reset: config registers, position counters, window pixels and pipeline valids clear;
// the line store is not cleared and needs no clearing pass
// depends on vconv2_pkg, vconv2_if and vconv2_mac
module valid_convolution_2x2 import vconv2_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vconv2_in_if.sink             in_if,
  vconv2_out_if.source          out_if,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMPW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

  coeff_t            coeff_r;
  logic [DIM_W-1:0]  width_r, height_r;
  logic [CMPW-1:0]   w_raw, w_lim;
  logic [DIM_W-1:0]  h_lim;

  logic [CW-1:0]     col_r, col_nxt, c_cur, c_m1;
  logic [IDX_W-1:0]  row_r, row_nxt, r_cur;
  logic              row_end, frame_done, accept, s1_ready;
  logic              mac_ready;

  logic [PIXEL_W-1:0]        mem [MAX_WIDTH];
  logic signed [PIXEL_W-1:0] above_r, s1_px_r;
  logic                      s1_v_r, s1_has_r, s1_fe_r;
  logic [IDX_W-1:0]          s1_row_r, s1_col_r;
  win_item_t                 s1_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r.tl <= COEFF_TL_RST;
      coeff_r.tr <= COEFF_TR_RST;
      coeff_r.bl <= COEFF_BL_RST;
      coeff_r.br <= COEFF_BR_RST;
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_COEFF_TL: coeff_r.tl <= cfg_wdata[COEFF_W-1:0];
        REG_COEFF_TR: coeff_r.tr <= cfg_wdata[COEFF_W-1:0];
        REG_COEFF_BL: coeff_r.bl <= cfg_wdata[COEFF_W-1:0];
        REG_COEFF_BR: coeff_r.br <= cfg_wdata[COEFF_W-1:0];
        REG_WIDTH:    width_r    <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT:   height_r   <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp dimensions to the supported range
  always_comb begin
    w_raw = CMPW'(width_r);
    if (w_raw < CMPW'(WIN)) begin
      w_lim = CMPW'(WIN);
    end else if (w_raw > CMPW'(MAX_WIDTH)) begin
      w_lim = CMPW'(MAX_WIDTH);
    end else begin
      w_lim = w_raw;
    end
    if (height_r < DIM_W'(WIN)) begin
      h_lim = DIM_W'(WIN);
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      h_lim = DIM_W'(MAX_HEIGHT);
    end else begin
      h_lim = height_r;
    end
  end

  assign s1_ready    = !s1_v_r || mac_ready;
  assign in_if.ready = s1_ready;
  assign accept      = in_if.valid && s1_ready;

  always_comb begin
    c_cur      = in_if.frame_start ? '0 : col_r;
    r_cur      = in_if.frame_start ? '0 : row_r;
    c_m1       = c_cur - CW'(1);
    row_end    = CMPW'(c_cur) >= (w_lim - CMPW'(1));
    frame_done = row_end && (DIM_W'(r_cur) >= (h_lim - DIM_W'(1)));
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (accept) begin
      if (frame_done) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = r_cur + IDX_W'(1);
      end else begin
        col_nxt = c_cur + CW'(1);
        row_nxt = r_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (s1_ready) begin
        s1_v_r <= in_if.valid;
      end
    end
  end

  // line store, read-first: the old entry of this column is the pixel above
  always_ff @(posedge clk) begin
    if (accept) begin
      above_r      <= mem[c_cur];
      mem[c_cur]   <= in_if.pixel;
      s1_px_r      <= in_if.pixel;
      s1_has_r     <= (r_cur != '0) && (c_cur != '0);
      s1_row_r     <= r_cur - IDX_W'(1);
      s1_col_r     <= IDX_W'(c_m1);
      s1_fe_r      <= frame_done;
    end
  end

  assign s1_item.above     = above_r;
  assign s1_item.px        = s1_px_r;
  assign s1_item.has_out   = s1_has_r;
  assign s1_item.row       = s1_row_r;
  assign s1_item.col       = s1_col_r;
  assign s1_item.frame_end = s1_fe_r;

  vconv2_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_v_r),
    .in_ready (mac_ready),
    .item     (s1_item),
    .coeff    (coeff_r),
    .out_if   (out_if)
  );

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.frame_start && !frame_done |=> col_r == CW'(1) && row_r == '0)
    else $error("position after frame start is not column one of row zero");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_done |=> col_r == '0 && row_r == '0)
    else $error("position did not return to origin after frame end");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !mac_ready |=> s1_v_r && $stable(s1_px_r) && $stable(above_r)
      && $stable(s1_has_r))
    else $error("stalled window stage lost or changed its transaction");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for valid_convolution_2x2: streams pixel frames under several
// kernel and size settings and checks every window sum against its own window model
// depends on vconv2_pkg, vconv2_if and the valid_convolution_2x2 design files
module testbench;
  import vconv2_pkg::*;

  typedef struct packed {
    logic signed [PIXEL_W-1:0] pixel;
    logic                      frame_start;
  } pixel_txn_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic [IDX_W-1:0]           row;
    logic [IDX_W-1:0]           col;
    logic                       frame_end;
  } window_sum_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  vconv2_in_if  in_if ();
  vconv2_out_if out_if ();

  valid_convolution_2x2 uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // window model state and its copy of the registers
  coeff_t                    kernel;
  logic [DIM_W-1:0]          width_reg;
  logic [DIM_W-1:0]          height_reg;
  logic signed [PIXEL_W-1:0] line_mem [MAX_WIDTH_DEF];
  logic signed [PIXEL_W-1:0] left_px;
  logic signed [PIXEL_W-1:0] diag_px;
  logic [IDX_W-1:0]          col_pos;
  logic [IDX_W-1:0]          row_pos;

  pixel_txn_t  pixel_feed [$];
  window_sum_t sums_due [$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v < WIN) return WIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void advance_window(input pixel_txn_t t);
    int w;
    int h;
    logic signed [PIXEL_W-1:0] above;
    logic row_end;
    logic frame_done;
    longint acc;
    window_sum_t s;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (t.frame_start) begin
      col_pos = '0;
      row_pos = '0;
    end
    above = line_mem[col_pos];
    row_end = (int'(col_pos) >= w - 1);
    frame_done = row_end && (int'(row_pos) >= h - 1);
    if (row_pos != '0 && col_pos != '0) begin
      acc = longint'(kernel.tl) * longint'(diag_px) + longint'(kernel.tr) * longint'(above)
          + longint'(kernel.bl) * longint'(left_px) + longint'(kernel.br) * longint'(t.pixel);
      s.result = acc[RESULT_W-1:0];
      s.row = row_pos - 1'b1;
      s.col = col_pos - 1'b1;
      s.frame_end = frame_done;
      sums_due.push_back(s);
    end
    diag_px = above;
    line_mem[col_pos] = t.pixel;
    left_px = t.pixel;
    if (frame_done) begin
      col_pos = '0;
      row_pos = '0;
    end else if (row_end) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic void check_field(input string what, input logic signed [RESULT_W-1:0] want,
                                      input logic signed [RESULT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // pixel driver
  always @(posedge clk) begin
    pixel_txn_t next_px;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_px = pixel_feed.pop_front();
        in_if.valid <= 1'b1;
        in_if.pixel <= next_px.pixel;
        in_if.frame_start <= next_px.frame_start;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      advance_window(pixel_txn_t'{in_if.pixel, in_if.frame_start});
  end

  // result receiver, with an occasional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    window_sum_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result %0d row %0d col %0d frame_end %0b", $time,
                 out_if.result, out_if.out_row, out_if.out_col, out_if.frame_end);
        errors++;
      end else begin
        want = sums_due.pop_front();
        check_field("result", want.result, out_if.result);
        check_field("out_row", want.row, out_if.out_row);
        check_field("out_col", want.col, out_if.out_col);
        check_field("frame_end", want.frame_end, out_if.frame_end);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_COEFF_TL: kernel.tl = data;
      REG_COEFF_TR: kernel.tr = data;
      REG_COEFF_BL: kernel.bl = data;
      REG_COEFF_BR: kernel.br = data;
      REG_WIDTH:    width_reg = data[DIM_W-1:0];
      REG_HEIGHT:   height_reg = data[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input coeff_t k, input logic [CFG_DATA_W-1:0] wd,
                           input logic [CFG_DATA_W-1:0] hd);
    write_reg(REG_COEFF_TL, k.tl);
    write_reg(REG_COEFF_TR, k.tr);
    write_reg(REG_COEFF_BL, k.bl);
    write_reg(REG_COEFF_BR, k.br);
    write_reg(REG_WIDTH, wd);
    write_reg(REG_HEIGHT, hd);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the feed to empty and every sum to arrive, then let the pipeline settle
  task automatic drain();
    do @(negedge clk);
    while (pixel_feed.size() != 0 || in_if.valid || sums_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void set_mode(input int m);
    case (m)
      1:       begin send_idle_pct = 59; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 59; end
      3:       begin send_idle_pct = 34; stall_pct = 34; end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // mostly small sizes, sometimes below two or above the maximum, junk in the upper bits
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    logic [DIM_W-1:0] d;
    case ($urandom_range(9))
      0:       d = $urandom_range(1);
      1:       d = $urandom_range(2047, 1025);
      2:       d = 11'd2;
      default: d = $urandom_range(8, 3);
    endcase
    return {(CFG_DATA_W-DIM_W)'($urandom), d};
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      3:       return 16'hffff;
      default: return $urandom;
    endcase
  endfunction

  // raster run that opens a new frame, with the odd frame_start mid-frame
  task automatic push_run(input int count, input int fs_pct);
    for (int i = 0; i < count; i++)
      pixel_feed.push_back(pixel_txn_t'{pick_pixel(), (i == 0) || ($urandom_range(99) < fs_pct)});
  endtask

  initial begin
    int n;
    logic [CFG_DATA_W-1:0] wd;
    in_if.valid = 1'b0;
    in_if.pixel = '0;
    in_if.frame_start = 1'b0;
    out_if.ready = 1'b0;
    kernel = coeff_t'{COEFF_TL_RST, COEFF_TR_RST, COEFF_BL_RST, COEFF_BR_RST};
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    left_px = '0;
    diag_px = '0;
    col_pos = '0;
    row_pos = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // full-scale sums of both signs, width one clamped to two, frames back to back
    configure(coeff_t'{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'd1, 16'd2);
    @(negedge clk);
    set_mode(0);
    pixel_feed.push_back(pixel_txn_t'{16'sh8000, 1'b1});
    repeat (3) pixel_feed.push_back(pixel_txn_t'{16'sh8000, 1'b0});
    repeat (4) pixel_feed.push_back(pixel_txn_t'{16'sh7fff, 1'b0});
    drain();

    // width zero clamped up, height above the maximum clamped down, restart mid-frame
    configure(coeff_t'{16'h7fff, 16'h8000, 16'h0001, 16'hffff}, 16'hf800, 16'h07ff);
    @(negedge clk);
    for (int i = 1; i <= 10; i++)
      pixel_feed.push_back(pixel_txn_t'{PIXEL_W'(i), (i == 1) || (i == 7)});
    drain();

    // largest legal sizes, no window completes
    configure(coeff_t'{pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff()},
              16'd1024, 16'd1024);
    @(negedge clk);
    set_mode(1);
    push_run(60, 0);
    drain();

    // one long two-row frame
    n = $urandom_range(200, 100);
    configure(coeff_t'{pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff()},
              CFG_DATA_W'(n), 16'd2);
    @(negedge clk);
    set_mode(3);
    push_run(2 * n, 0);
    drain();

    for (int p = 0; p < 10; p++) begin
      wd = (p == 4) ? 16'd3 : pick_dim();
      configure(coeff_t'{pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff()},
                wd, pick_dim());
      @(negedge clk);
      set_mode(p % 4);
      if (p == 4)
        hold_asks++;
      if (p == 6) begin
        push_run(50, 2);
        drain();
        push_run(50, 2);
      end else begin
        push_run(100, 2);
      end
      drain();
    end

    if (errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
